### src/rrsa_pkg.sv
// Shared types and constants for the rounded rectangle shadow alpha core.
// No dependencies; every other file imports this package.

package rrsa_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL   = 2'd3;

    localparam int RAD_W     = 8;     // blur radius width
    localparam int LEVEL_W   = 8;     // alpha level width
    localparam int PIX_W     = 32;    // ARGB word
    localparam int ALPHA_LSB = 24;

    localparam int                 FRAME_RESET  = 64;
    localparam logic [RAD_W-1:0]   RADIUS_RESET = 8'd8;
    localparam logic [LEVEL_W-1:0] PEAK_RESET   = 8'd128;

    // Control that travels alongside each pixel
    typedef struct packed {
        logic vld;
        logic core;   // inside the core rectangle: full level
        logic zero;   // at or beyond the radius: transparent
    } t_side;

endpackage

### src/rrsa_isqrt.sv
// Pipelined integer square root of (i_val << 2*FRAC_BITS), one root bit per stage.
// Depends on rrsa_pkg for the side-band struct.

module rrsa_isqrt
    import rrsa_pkg::*;
#(
    parameter int IN_W      = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_side                         i_side,
    input  logic [IN_W-1:0]               i_val,
    output t_side                         o_side,
    output logic [IN_W/2+FRAC_BITS-1:0]   o_root
);

    localparam int R_W   = IN_W/2 + FRAC_BITS;
    localparam int REM_W = R_W + 2;
    localparam int PAIRS = IN_W/2;

    t_side             r_side [R_W];
    logic [IN_W-1:0]   r_val  [R_W];
    logic [REM_W-1:0]  r_rem  [R_W];
    logic [R_W-1:0]    r_root [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        t_side            p_side;
        logic [IN_W-1:0]  p_val;
        logic [REM_W-1:0] p_rem;
        logic [R_W-1:0]   p_root;
        logic [1:0]       pair;
        logic [REM_W-1:0] acc;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] n_rem;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_side = i_side;
            assign p_val  = i_val;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_side = r_side[k-1];
            assign p_val  = r_val[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        // the low 2*FRAC_BITS bits of the radicand are all zero fraction bits
        if (k < PAIRS) begin : g_data
            assign pair = p_val[IN_W-1-2*k -: 2];
        end else begin : g_frac
            assign pair = 2'b00;
        end

        assign acc   = {p_rem[R_W-1:0], pair};
        assign trial = {p_root, 2'b01};
        assign ge    = (acc >= trial);
        assign n_rem = ge ? (acc - trial) : acc;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else if (i_en) begin
                r_side[k] <= p_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= p_val;
                r_rem[k]  <= n_rem;
                r_root[k] <= {p_root[R_W-2:0], ge};
            end
        end
    end

    assign o_side = r_side[R_W-1];
    assign o_root = r_root[R_W-1];

endmodule

### src/rrsa_div.sv
// Pipelined restoring divider: quotient of a root by the blur radius, one bit per stage.
// Depends on rrsa_pkg; the quotient is known to fit in FRAC_BITS bits.

module rrsa_div
    import rrsa_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_side                         i_side,
    input  logic [RAD_W+FRAC_BITS-1:0]    i_num,
    input  logic [RAD_W-1:0]              i_den,
    output t_side                         o_side,
    output logic [FRAC_BITS-1:0]          o_quot
);

    localparam int F = FRAC_BITS;

    t_side             r_side [F];
    logic [RAD_W-1:0]  r_rem  [F];
    logic [F-1:0]      r_low  [F];
    logic [F-1:0]      r_quot [F];

    for (genvar j = 0; j < F; j++) begin : g_stage
        t_side            p_side;
        logic [RAD_W-1:0] p_rem;
        logic [F-1:0]     p_low;
        logic [F-1:0]     p_quot;
        logic [RAD_W:0]   acc;
        logic [RAD_W:0]   n_rem;
        logic             ge;

        if (j == 0) begin : g_first
            assign p_side = i_side;
            assign p_rem  = i_num[RAD_W+F-1:F];
            assign p_low  = i_num[F-1:0];
            assign p_quot = '0;
        end else begin : g_next
            assign p_side = r_side[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_low  = r_low[j-1];
            assign p_quot = r_quot[j-1];
        end

        assign acc   = {p_rem, p_low[F-1]};
        assign ge    = (acc >= {1'b0, i_den});
        assign n_rem = ge ? (acc - {1'b0, i_den}) : acc;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j] <= '0;
            end else if (i_en) begin
                r_side[j] <= p_side;
            end
        end

        // remainder stays below the divisor, so the top bit drops
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem[RAD_W-1:0];
                r_low[j]  <= {p_low[F-2:0], 1'b0};
                r_quot[j] <= {p_quot[F-2:0], ge};
            end
        end
    end

    assign o_side = r_side[F-1];
    assign o_quot = r_quot[F-1];

endmodule

### src/rounded_rect_shadow_alpha_core.sv
// Top level of the rounded rectangle shadow alpha core: edge distance, square root,
// division and smoothstep pipeline with a two-entry output buffer.
// Depends on rrsa_pkg, rrsa_isqrt and rrsa_div.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: pos_x, pos_y
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pixel_word
//  cfg       in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One pixel per clock while s_axis_tready is high; the pipeline has one stage per root bit
// in the square root and one per quotient bit in the divider.
// Synchronous reset clears all valid bits and the output buffer and loads register defaults.
// A stall on m_axis freezes the whole pipeline only when the output buffer is full; it holds
// a second result, so s_axis_tready only drops once two results are waiting.

module rounded_rect_shadow_alpha_core
    import rrsa_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [COORD_BITS-1:0]                  i_cfg_data,
    // pixel coordinates in
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,  // pos_x, pos_y, zero pad
    // pixels out
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [PIX_W-1:0]                       m_axis_tdata   // pixel_word
);

    localparam int CW    = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int SW    = CW + 2;
    localparam int D2_W  = 2*RAD_W;
    localparam int SQ_W  = RAD_W + F;
    localparam int DD_W  = 2*F;
    localparam int K_W   = F + 2;
    localparam int DK_W  = 2*F + 2;
    localparam int TL_W  = F + 1 + LEVEL_W;

    // configuration registers
    logic [CW-1:0]      r_frame_w;
    logic [CW-1:0]      r_frame_h;
    logic [RAD_W-1:0]   r_radius;
    logic [LEVEL_W-1:0] r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= CW'(FRAME_RESET);
            r_frame_h <= CW'(FRAME_RESET);
            r_radius  <= RADIUS_RESET;
            r_peak    <= PEAK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                CFG_BLUR_RADIUS:  r_radius  <= i_cfg_data[RAD_W-1:0];
                CFG_PEAK_LEVEL:   r_peak    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Distance past the core edge along one axis, saturated to the radius range.
    function automatic logic [RAD_W-1:0] axis_dist(input logic [CW-1:0]    p,
                                                   input logic [CW-1:0]    size,
                                                   input logic [RAD_W-1:0] r);
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] span;
        sp  = signed'(SW'(p));
        sr  = signed'(SW'(r));
        lim = signed'(SW'(size)) - sr;
        if (sp < sr) begin
            span = sr - sp;
        end else if (sp >= lim) begin
            span = sp - lim + signed'(SW'(1));
        end else begin
            span = '0;
        end
        // anything past the radius range is transparent anyway
        if (span > signed'(SW'({RAD_W{1'b1}}))) begin
            return {RAD_W{1'b1}};
        end
        return span[RAD_W-1:0];
    endfunction

    logic en;
    logic take;
    logic push;

    // stage 1: per-axis distances
    t_side            r_s1_side;
    logic [RAD_W-1:0] r_s1_dx;
    logic [RAD_W-1:0] r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side <= '0;
        end else if (en) begin
            r_s1_side <= '{vld: s_axis_tvalid, core: 1'b0, zero: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dx <= axis_dist(s_axis_tdata[CW-1:0], r_frame_w, r_radius);
            r_s1_dy <= axis_dist(s_axis_tdata[2*CW-1:CW], r_frame_h, r_radius);
        end
    end

    // stage 2: squared distance
    t_side           r_s2_side;
    logic [D2_W:0]   r_s2_dist2;
    logic [D2_W-1:0] w_dx2;
    logic [D2_W-1:0] w_dy2;

    assign w_dx2 = D2_W'(r_s1_dx) * D2_W'(r_s1_dx);
    assign w_dy2 = D2_W'(r_s1_dy) * D2_W'(r_s1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side <= '0;
        end else if (en) begin
            r_s2_side <= '{vld:  r_s1_side.vld,
                           core: (r_s1_dx == '0) && (r_s1_dy == '0),
                           zero: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_dist2 <= (D2_W+1)'(w_dx2) + (D2_W+1)'(w_dy2);
        end
    end

    // stage 3: compare against the squared radius
    t_side           r_s3_side;
    logic [D2_W-1:0] r_s3_dist2;
    logic [D2_W-1:0] w_r2;

    assign w_r2 = D2_W'(r_radius) * D2_W'(r_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_side <= '0;
        end else if (en) begin
            r_s3_side <= '{vld:  r_s2_side.vld,
                           core: r_s2_side.core,
                           zero: (r_s2_dist2 >= (D2_W+1)'(w_r2)) || (r_radius == '0)};
        end
    end

    // inside the band the squared distance is below the squared radius and fits
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_dist2 <= r_s2_dist2[D2_W-1:0];
        end
    end

    // square root, then divide by the radius
    t_side           w_sq_side;
    logic [SQ_W-1:0] w_root;
    t_side           w_dv_side;
    logic [F-1:0]    w_d;

    rrsa_isqrt #(
        .IN_W      (D2_W),
        .FRAC_BITS (F)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (r_s3_side),
        .i_val   (r_s3_dist2),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    rrsa_div #(
        .FRAC_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (w_sq_side),
        .i_num   (w_root),
        .i_den   (r_radius),
        .o_side  (w_dv_side),
        .o_quot  (w_d)
    );

    // smoothstep p1: d squared
    t_side           r_p1_side;
    logic [F-1:0]    r_p1_d;
    logic [F-1:0]    r_p1_d2;
    logic [DD_W-1:0] w_dd;

    assign w_dd = DD_W'(w_d) * DD_W'(w_d);

    // smoothstep p2: d^2 * (3 - 2d)
    t_side           r_p2_side;
    logic [K_W-1:0]  r_p2_p;
    logic [K_W-1:0]  w_k;
    logic [DK_W-1:0] w_dk;

    assign w_k  = K_W'(3) * (K_W'(1) << F) - {1'b0, r_p1_d, 1'b0};
    assign w_dk = DK_W'(r_p1_d2) * DK_W'(w_k);

    // smoothstep p3: t = 1 - p, saturated at zero
    t_side          r_p3_side;
    logic [F:0]     r_p3_t;
    logic [K_W-1:0] w_one;

    assign w_one = K_W'(1) << F;

    // p4: scale the level
    t_side              r_p4_side;
    logic [LEVEL_W-1:0] r_p4_alpha;
    logic [TL_W-1:0]    w_tl;
    logic [LEVEL_W-1:0] w_alpha;

    assign w_tl = TL_W'(r_p3_t) * TL_W'(r_peak);

    always_comb begin
        if (r_p3_side.core) begin
            w_alpha = r_peak;
        end else if (r_p3_side.zero) begin
            w_alpha = '0;
        end else begin
            w_alpha = w_tl[F+LEVEL_W-1:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side <= '0;
            r_p2_side <= '0;
            r_p3_side <= '0;
            r_p4_side <= '0;
        end else if (en) begin
            r_p1_side <= w_dv_side;
            r_p2_side <= r_p1_side;
            r_p3_side <= r_p2_side;
            r_p4_side <= r_p3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_d     <= w_d;
            r_p1_d2    <= w_dd[DD_W-1:F];
            r_p2_p     <= w_dk[DK_W-1:F];
            r_p3_t     <= (r_p2_p > w_one) ? '0 : w_one[F:0] - r_p2_p[F:0];
            r_p4_alpha <= w_alpha;
        end
    end

    // output buffer: presented entry plus one skid entry
    logic               r_out_vld;
    logic               r_skid_vld;
    logic [LEVEL_W-1:0] r_out_alpha;
    logic [LEVEL_W-1:0] r_skid_alpha;

    assign en   = !r_skid_vld;
    assign take = r_out_vld && m_axis_tready;
    assign push = en && r_p4_side.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_alpha <= r_skid_alpha;
            end
        end else if (push) begin
            if (!r_out_vld || take) begin
                r_out_alpha <= r_p4_alpha;
            end else begin
                r_skid_alpha <= r_p4_alpha;
            end
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_alpha, {ALPHA_LSB{1'b0}}};

endmodule

### src/rrsa_checker.sv
// Port-level checks for rounded_rect_shadow_alpha_core, attached by bind.
// Depends on rrsa_pkg for the pixel word layout.

module rrsa_checker
    import rrsa_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata
);

    // hold a stalled transaction
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_colour_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[ALPHA_LSB-1:0] == '0)
        else $error("colour bytes not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("buffer not empty after reset");

    // input only backs up once a finished result is waiting
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind rounded_rect_shadow_alpha_core rrsa_checker u_rrsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/rounded_rect_shadow_alpha_core_tb.sv
// Self-checking bench for rounded_rect_shadow_alpha_core: streams pixel coordinates
// under several register settings and checks every output pixel against a local predictor.
// Depends on rrsa_pkg and the core RTL only.
`timescale 1ns / 100ps

module rounded_rect_shadow_alpha_core_tb;
    import rrsa_pkg::*;

    localparam int CRD_W = 13;
    localparam int FRC_W = 16;
    localparam int IN_W  = ((2*CRD_W+7)/8)*8;
    localparam longint unsigned UNIT = 64'd1 << FRC_W;
    localparam int LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 2*FRC_W + 32;

    typedef struct packed {
        logic [CRD_W-1:0] pos_y;
        logic [CRD_W-1:0] pos_x;
    } t_coord;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_FRAME_WIDTH;
    logic [CRD_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;  // pos_x, pos_y, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;       // pixel_word

    // register copies used by the predictor
    logic [CRD_W-1:0]   frame_w = CRD_W'(FRAME_RESET);
    logic [CRD_W-1:0]   frame_h = CRD_W'(FRAME_RESET);
    logic [RAD_W-1:0]   blur_r  = RADIUS_RESET;
    logic [LEVEL_W-1:0] peak    = PEAK_RESET;

    t_coord           coord_q[$];
    logic [PIX_W-1:0] pixel_q[$];
    int               err_cnt = 0;
    int               cyc = 0;
    bit               src_idle = 1'b0;
    bit               snk_idle = 1'b0;
    int               src_gap = 0;
    int               snk_stall = 0;

    rounded_rect_shadow_alpha_core #(
        .COORD_BITS(CRD_W),
        .FRAC_BITS (FRC_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // distance past the core edge; the edge at zero wins where the band covers both
    function automatic int edge_gap(int p, int size, int r);
        if (p < r)
            return r - p;
        if (p >= size - r)
            return p - (size - r - 1);
        return 0;
    endfunction

    function automatic logic [PIX_W-1:0] shadow_pixel(logic [CRD_W-1:0] px,
                                                      logic [CRD_W-1:0] py);
        int dx, dy, r;
        longint unsigned dist2, rq, root, cand, d, d2, p, t, lvl;
        r  = int'(blur_r);
        dx = edge_gap(int'(px), int'(frame_w), r);
        dy = edge_gap(int'(py), int'(frame_h), r);
        dist2 = longint'(dx*dx + dy*dy);
        if (dx == 0 && dy == 0) begin
            lvl = 64'(peak);
        end else if (r == 0 || dist2 >= longint'(r*r)) begin
            lvl = 0;
        end else begin
            // floor square root of dist2 in Q.FRC_W, found bit by bit from the top
            rq   = dist2 << (2*FRC_W);
            root = 0;
            for (int b = 8 + FRC_W; b >= 0; b--) begin
                cand = root | (64'd1 << b);
                if (cand*cand <= rq)
                    root = cand;
            end
            d = root / longint'(r);
            if (d > UNIT)
                d = UNIT;
            d2  = (d*d) >> FRC_W;
            p   = (d2 * (3*UNIT - 2*d)) >> FRC_W;
            t   = (p > UNIT) ? 0 : UNIT - p;
            lvl = (t * longint'(peak)) >> FRC_W;
        end
        return {lvl[LEVEL_W-1:0], {ALPHA_LSB{1'b0}}};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // bias coordinates towards the falloff bands and the frame edges
    function automatic logic [CRD_W-1:0] pick_coord(int size, int r);
        int v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom_range(0, r + 1);
            2, 3: v = size - r - 2 + int'($urandom_range(0, r + 3));
            4: v = $urandom_range(0, size - 1);
            5: v = $urandom;
            6: v = size + int'($urandom_range(0, 20));
            default: v = $urandom_range(0, size + r);
        endcase
        return v[CRD_W-1:0];
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CRD_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_FRAME_WIDTH:  frame_w = data;
            CFG_FRAME_HEIGHT: frame_h = data;
            CFG_BLUR_RADIUS:  blur_r  = data[RAD_W-1:0];
            CFG_PEAK_LEVEL:   peak    = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int w, int h, int r, int lv);
        cfg_write(CFG_FRAME_WIDTH,  w[CRD_W-1:0]);
        cfg_write(CFG_FRAME_HEIGHT, h[CRD_W-1:0]);
        cfg_write(CFG_BLUR_RADIUS,  r[CRD_W-1:0]);
        cfg_write(CFG_PEAK_LEVEL,   lv[CRD_W-1:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_xy(int x, int y);
        t_coord c;
        c.pos_x = x[CRD_W-1:0];
        c.pos_y = y[CRD_W-1:0];
        coord_q.push_back(c);
    endtask

    task automatic wait_drained();
        while (coord_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0)
            @(posedge i_clk);
    endtask

    // source side: predict on each transaction, then load the next coordinate after any gap
    always @(posedge i_clk) begin : drive_coords
        bit     busy;
        t_coord c;
        busy = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) begin
            pixel_q.push_back(shadow_pixel(s_axis_tdata[CRD_W-1:0],
                                           s_axis_tdata[2*CRD_W-1:CRD_W]));
            busy = 1'b0;
        end
        if (!busy) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (i_rst_n && coord_q.size() != 0) begin
                c = coord_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_W-2*CRD_W){1'b0}}, c.pos_y, c.pos_x};
                src_gap = src_idle ? gap_len() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side: random back-pressure
    always @(posedge i_clk) begin
        if (snk_stall != 0) begin
            snk_stall = snk_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (snk_idle && $urandom_range(0, 3) == 0)
                snk_stall = gap_len();
        end
    end

    always @(posedge i_clk) begin : check_pixels
        logic [PIX_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                $error("pixel_word: no pixel expected, got %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pixel_q.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("pixel_word mismatch: expected %h, got %h", want, m_axis_tdata);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int w, h, r, lv;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: corners, edges, core, far outside
        src_idle = 1'b1;
        snk_idle = 1'b1;
        push_xy(0, 0);
        push_xy(8191, 8191);
        push_xy(8, 8);
        push_xy(7, 8);
        push_xy(32, 0);
        push_xy(32, 1);
        push_xy(55, 32);
        push_xy(56, 32);
        push_xy(63, 63);
        push_xy(64, 32);
        push_xy(4, 4);
        push_xy(0, 4095);
        push_xy(4096, 10);
        push_xy(32, 32);
        push_xy(5, 60);
        wait_drained();

        // zero radius: only core or transparent
        set_regs(1, 1, 0, 255);
        push_xy(0, 0);
        push_xy(1, 0);
        push_xy(0, 1);
        push_xy(8191, 8191);
        wait_drained();

        // band wider than the frame: the edge at zero takes precedence
        set_regs(10, 10, 255, 255);
        push_xy(0, 0);
        push_xy(5, 5);
        push_xy(9, 9);
        push_xy(4, 7);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin w = 8191; h = 8191; r = 255; lv = 255; end
                1: begin w = 1;    h = 1;    r = 0;   lv = 0;   end
                default: begin
                    w  = $urandom_range(1, 700);
                    h  = $urandom_range(1, 700);
                    r  = $urandom_range(1, 255);
                    lv = $urandom_range(0, 255);
                end
            endcase
            set_regs(w, h, r, lv);
            src_idle = (ph % 3 != 2);
            snk_idle = (ph % 3 != 2);
            for (int n = 0; n < 150; n++)
                push_xy(int'(pick_coord(w, r)), int'(pick_coord(h, r)));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
